@@ hw/rtl/rpv_pkg.sv @@
`timescale 1ns / 1ps

package rpv_pkg;

  localparam int unsigned ValBits = 63;
  localparam int unsigned CfgIdxBits = 1;

  // opcodes of an input item
  localparam logic [1:0] OP_VOTE    = 2'd0;
  localparam logic [1:0] OP_ABSTAIN = 2'd1;
  localparam logic [1:0] OP_DECIDE  = 2'd2;
  localparam logic [1:0] OP_UNUSED  = 2'd3;

  // configuration register indexes
  localparam logic [CfgIdxBits-1:0] REG_CURRENT = 1'd0;
  localparam logic [CfgIdxBits-1:0] REG_TARGET  = 1'd1;

  typedef logic [ValBits-1:0] val_t;

  typedef struct packed {
    logic [1:0] opcode;
    val_t       vote_value;
  } rpv_in_t;

  typedef struct packed {
    val_t chosen_value;
    logic changed;
    logic votes_lost;
  } rpv_out_t;

endpackage

@@ hw/rtl/ranged_plurality_vote.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake                     Payload
// item in   input      start & !busy accepts         in_item_i  (opcode, vote_value)
// result    output     result_valid_o, one cycle     out_item_o (chosen, changed, lost)
// config    input      cfg_we_i writes cfg_idx_i     cfg_wdata_i
//
// One item at a time. A vote or abstention goes through PREP, which drops an out-of-range
// value or stores the first one directly, and else through SEARCH until a match or the last
// entry; a decide tallies the target that way, then walks all entries_used entries over
// the table's single read port, whose read is registered, and registers the result.
// Opcode 3 is dropped at once.
// Reset clears the control state and the fill count; the table itself needs no
// clearing pass since only entries below the fill count are read.
// The receiver cannot stall: a result is flagged by result_valid_o for exactly one cycle.

module ranged_plurality_vote #(
  parameter int unsigned ENTRIES    = 64,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  rpv_pkg::rpv_in_t                   in_item_i,
  output logic                               result_valid_o,
  output rpv_pkg::rpv_out_t                  out_item_o,
  input  logic                               cfg_we_i,
  input  logic [rpv_pkg::CfgIdxBits-1:0]     cfg_idx_i,
  input  rpv_pkg::val_t                      cfg_wdata_i
);
  import rpv_pkg::*;

  localparam int unsigned AW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  typedef enum logic [1:0] {
    IDLE,
    PREP,
    SEARCH,
    WALK
  } state_e;

  state_e                state_q;
  val_t                  cur_q, tgt_q;
  val_t                  lo_q, hi_q;
  val_t                  v_q;
  logic                  dec_q;
  logic [CW-1:0]         idx_q, ridx_q, used_q;
  logic                  rvalid_q;
  logic                  lost_q;
  val_t                  best_q;
  logic [COUNT_BITS-1:0] weight_q;
  rpv_out_t              out_q;
  logic                  out_valid_q;

  // table ports
  logic                  tbl_we;
  logic [AW-1:0]         tbl_waddr;
  val_t                  tbl_wval;
  logic [COUNT_BITS-1:0] tbl_wcnt;
  val_t                  rd_val;
  logic [COUNT_BITS-1:0] rd_cnt;

  logic                  accept;
  logic                  in_rng;
  logic                  issue;
  logic                  match;
  logic                  last;
  logic                  full;
  logic                  hit;
  logic                  cand;
  val_t                  final_best;

  rpv_table #(
    .ENTRIES   (ENTRIES),
    .COUNT_BITS(COUNT_BITS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (tbl_we),
    .waddr_i(tbl_waddr),
    .wval_i (tbl_wval),
    .wcnt_i (tbl_wcnt),
    .raddr_i(idx_q[AW-1:0]),
    .rval_o (rd_val),
    .rcnt_o (rd_cnt)
  );

  assign accept = start && !busy;
  assign in_rng = (v_q >= lo_q) && (v_q <= hi_q);
  assign issue  = idx_q < used_q;
  assign full   = used_q == CW'(ENTRIES);
  assign match  = rvalid_q && (rd_val == v_q);
  assign last   = rvalid_q && ((ridx_q + CW'(1)) == used_q);

  // argmax step: an in-range entry with more votes, or as many and a smaller value
  assign hit  = (rd_val >= lo_q) && (rd_val <= hi_q) && (rd_cnt != '0);
  assign cand = rvalid_q && hit &&
                ((rd_cnt > weight_q) || ((rd_cnt == weight_q) && (rd_val < best_q)));
  assign final_best = cand ? rd_val : best_q;

  // write back: bump a matching count, or append a new value at the fill count
  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = used_q[AW-1:0];
    tbl_wval  = v_q;
    tbl_wcnt  = COUNT_BITS'(1);
    if (state_q == PREP && in_rng && used_q == '0) begin
      tbl_we = 1'b1;
    end else if (state_q == SEARCH) begin
      if (match) begin
        tbl_we    = 1'b1;
        tbl_waddr = ridx_q[AW-1:0];
        tbl_wcnt  = (rd_cnt == '1) ? rd_cnt : rd_cnt + COUNT_BITS'(1);
      end else if (last && !full) begin
        tbl_we = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= IDLE;
      cur_q       <= '0;
      tgt_q       <= '0;
      used_q      <= '0;
      lost_q      <= 1'b0;
      idx_q       <= '0;
      ridx_q      <= '0;
      rvalid_q    <= 1'b0;
      dec_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_CURRENT: cur_q <= cfg_wdata_i;
          REG_TARGET:  tgt_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      case (state_q)
        IDLE: begin
          if (accept && in_item_i.opcode != OP_UNUSED) begin
            // latch the range and the value to tally
            lo_q     <= (cur_q < tgt_q) ? cur_q : tgt_q;
            hi_q     <= (cur_q < tgt_q) ? tgt_q : cur_q;
            best_q   <= cur_q;
            weight_q <= '0;
            idx_q    <= '0;
            rvalid_q <= 1'b0;
            dec_q    <= in_item_i.opcode == OP_DECIDE;
            case (in_item_i.opcode)
              OP_VOTE:    v_q <= in_item_i.vote_value;
              OP_ABSTAIN: v_q <= cur_q;
              default:    v_q <= tgt_q;
            endcase
            state_q <= PREP;
          end
        end
        PREP: begin
          if (!in_rng) begin
            // drop an out-of-range vote silently
            state_q <= dec_q ? WALK : IDLE;
          end else if (used_q == '0) begin
            used_q  <= CW'(1);
            state_q <= dec_q ? WALK : IDLE;
          end else begin
            state_q <= SEARCH;
          end
        end
        SEARCH: begin
          idx_q    <= idx_q + CW'(issue);
          rvalid_q <= issue;
          ridx_q   <= idx_q;
          if (match || last) begin
            if (!match) begin
              if (full) lost_q <= 1'b1;
              else      used_q <= used_q + CW'(1);
            end
            idx_q    <= '0;
            rvalid_q <= 1'b0;
            state_q  <= dec_q ? WALK : IDLE;
          end
        end
        WALK: begin
          idx_q    <= idx_q + CW'(issue);
          rvalid_q <= issue;
          ridx_q   <= idx_q;
          if (cand) begin
            best_q   <= rd_val;
            weight_q <= rd_cnt;
          end
          if (last || used_q == '0) begin
            // emit the winner and clear the round
            out_q.chosen_value <= final_best;
            out_q.changed      <= final_best != cur_q;
            out_q.votes_lost   <= lost_q;
            out_valid_q        <= 1'b1;
            used_q             <= '0;
            lost_q             <= 1'b0;
            idx_q              <= '0;
            rvalid_q           <= 1'b0;
            state_q            <= IDLE;
          end
        end
        default: state_q <= IDLE;
      endcase
    end
  end

  assign busy           = state_q != IDLE;
  assign result_valid_o = out_valid_q;
  assign out_item_o     = out_q;

endmodule

@@ hw/rtl/rpv_table.sv @@
`timescale 1ns / 1ps

module rpv_table #(
  parameter int unsigned ENTRIES    = 64,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(ENTRIES)-1:0] waddr_i,
  input  rpv_pkg::val_t              wval_i,
  input  logic [COUNT_BITS-1:0]      wcnt_i,
  input  logic [$clog2(ENTRIES)-1:0] raddr_i,
  output rpv_pkg::val_t              rval_o,
  output logic [COUNT_BITS-1:0]      rcnt_o
);
  import rpv_pkg::*;

  val_t                  val_mem [ENTRIES];
  logic [COUNT_BITS-1:0] cnt_mem [ENTRIES];
  val_t                  rval_q;
  logic [COUNT_BITS-1:0] rcnt_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      val_mem[waddr_i] <= wval_i;
      cnt_mem[waddr_i] <= wcnt_i;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    rval_q <= val_mem[raddr_i];
    rcnt_q <= cnt_mem[raddr_i];
  end

  assign rval_o = rval_q;
  assign rcnt_o = rcnt_q;

endmodule

@@ hw/rtl/rpv_checker.sv @@
`timescale 1ns / 1ps

module rpv_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input rpv_pkg::rpv_in_t in_item_i,
  input logic             result_valid_o
);
  import rpv_pkg::*;

  // an accepted real item always raises busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && in_item_i.opcode != OP_UNUSED) |=> busy)
    else $error("accepted item did not raise busy");

  // results are single-cycle strobes, never back to back
  a_no_double: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for two cycles");

  // a result follows a busy cycle
  a_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result without preceding work");

  // the block is idle when it shows a result
  a_idle_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("busy while showing a result");

endmodule

bind ranged_plurality_vote rpv_checker u_rpv_checker (.*);

@@ bench/tb_ranged_plurality_vote.sv @@
`timescale 1ns / 1ps

module tb_ranged_plurality_vote;
  import rpv_pkg::*;

  localparam int unsigned ENTRIES      = 64;
  localparam int unsigned COUNT_BITS   = 16;
  localparam int unsigned RANDOM_ITEMS = 1350;
  // a vote can search the whole table, a decide walks it once more
  localparam int unsigned QUIET_CYCLES = 2 * ENTRIES + 16;
  // upper bound for the hung-block guard below
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam val_t        VAL_MAX      = '1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  rpv_in_t in_item = '0;
  logic result_valid;
  rpv_out_t out_item;
  logic cfg_we = 1'b0;
  logic [CfgIdxBits-1:0] cfg_idx = '0;
  val_t cfg_wdata = '0;

  // pending items for the driver, and decisions still owed by the block
  rpv_in_t  ballot_q[$];
  rpv_out_t verdict_q[$];

  // shadow of the block: settings, tally table, fill count and lost flag
  val_t                  cur_setting = '0;
  val_t                  tgt_setting = '0;
  val_t                  tbl_val[ENTRIES];
  logic [COUNT_BITS-1:0] tbl_cnt[ENTRIES];
  int unsigned           tbl_used = 0;
  bit                    tbl_dropped = 1'b0;

  bit          sender_idle_en = 1'b1;
  int unsigned cast_total = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;
  rpv_out_t    due;

  ranged_plurality_vote #(
    .ENTRIES   (ENTRIES),
    .COUNT_BITS(COUNT_BITS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .in_item_i     (in_item),
    .result_valid_o(result_valid),
    .out_item_o    (out_item),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata)
  );

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Tally predictor
  // ---------------------------------------------------------------------------

  // True when v lies between the two settings, whichever order they are in.
  function automatic bit in_band(val_t v);
    val_t lo;
    val_t hi;
    lo = (cur_setting < tgt_setting) ? cur_setting : tgt_setting;
    hi = (cur_setting < tgt_setting) ? tgt_setting : cur_setting;
    return (v >= lo) && (v <= hi);
  endfunction

  // Drop out-of-band votes silently; bump a known value, saturating; claim a
  // free entry for a new value, or raise the lost flag when the table is full.
  function automatic void count_vote(val_t v);
    if (!in_band(v)) return;
    for (int i = 0; i < tbl_used; i++) begin
      if (tbl_val[i] == v) begin
        if (tbl_cnt[i] != '1) tbl_cnt[i] = tbl_cnt[i] + 1'b1;
        return;
      end
    end
    if (tbl_used < ENTRIES) begin
      tbl_val[tbl_used] = v;
      tbl_cnt[tbl_used] = COUNT_BITS'(1);
      tbl_used++;
    end else begin
      tbl_dropped = 1'b1;
    end
  endfunction

  // Add the own vote for the target, pick the heaviest in-band value (smallest
  // on ties, current setting when nothing qualifies), then clear the round.
  // The band is checked again here since the settings may move mid-round.
  function automatic rpv_out_t close_round();
    rpv_out_t              res;
    val_t                  best;
    logic [COUNT_BITS-1:0] weight;
    count_vote(tgt_setting);
    best   = cur_setting;
    weight = '0;
    for (int i = 0; i < tbl_used; i++) begin
      if (in_band(tbl_val[i]) && tbl_cnt[i] != 0 &&
          (tbl_cnt[i] > weight || (tbl_cnt[i] == weight && tbl_val[i] < best))) begin
        best   = tbl_val[i];
        weight = tbl_cnt[i];
      end
    end
    res.chosen_value = best;
    res.changed      = (best != cur_setting);
    res.votes_lost   = tbl_dropped;
    for (int i = 0; i < ENTRIES; i++) tbl_cnt[i] = '0;
    tbl_used    = 0;
    tbl_dropped = 1'b0;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: feed items from ballot_q, predict each one as it is accepted
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        case (in_item.opcode)
          OP_VOTE:    count_vote(in_item.vote_value);
          OP_ABSTAIN: count_vote(cur_setting);
          OP_DECIDE:  verdict_q.push_back(close_round());
          default: ;
        endcase
      end
      // hold the item while the block is busy; otherwise launch the next one
      // or idle now and then
      if (!(start && busy)) begin
        if (ballot_q.size() != 0 &&
            !(sender_idle_en && $urandom_range(0, 99) < 25)) begin
          start   <= 1'b1;
          in_item <= ballot_q.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each result with the oldest owed decision
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && result_valid) begin
      if (verdict_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("%0t: result with none owed: chosen=%0d changed=%0b lost=%0b", $realtime,
                   out_item.chosen_value, out_item.changed, out_item.votes_lost);
      end else begin
        due = verdict_q.pop_front();
        if (out_item.chosen_value !== due.chosen_value || out_item.changed !== due.changed ||
            out_item.votes_lost !== due.votes_lost) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: decision mismatch: expected chosen=%0d changed=%0b lost=%0b, %s%0d %s%0b %s%0b",
                     $realtime, due.chosen_value, due.changed, due.votes_lost,
                     "got chosen=", out_item.chosen_value, "changed=", out_item.changed,
                     "lost=", out_item.votes_lost);
        end
      end
    end
  end

  // guard against a hung block
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d decisions still owed", cycle_cnt,
               verdict_q.size());
      $display("tb_ranged_plurality_vote: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic val_t rand_val();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[62:0];
  endfunction

  // Uniform-ish pick within [lo, hi].
  function automatic val_t pick_in(val_t lo, val_t hi);
    logic [63:0] span;
    logic [63:0] r;
    span = {1'b0, hi} - {1'b0, lo};
    r    = {1'b0, rand_val()};
    if (span != {1'b0, VAL_MAX}) r = r % (span + 1);
    return lo + r[62:0];
  endfunction

  // Queue one item; unused opcodes do not count toward the item budget.
  task automatic post(logic [1:0] op, val_t v);
    rpv_in_t it;
    it.opcode     = op;
    it.vote_value = v;
    ballot_q.push_back(it);
    if (op != OP_UNUSED) cast_total++;
  endtask

  // Drain: every item accepted, block idle, no decision owed, then a quiet
  // stretch so an item without a result has surely finished.
  task automatic settle();
    @(negedge clk_i);
    while (ballot_q.size() != 0 || start || busy !== 1'b0 || verdict_q.size() != 0)
      @(negedge clk_i);
    repeat (QUIET_CYCLES) @(negedge clk_i);
  endtask

  // Write one register and track it in the shadow. Call only while idle.
  task automatic write_setting(logic [CfgIdxBits-1:0] idx, val_t v);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == REG_CURRENT) cur_setting = v;
    else tgt_setting = v;
  endtask

  // Pick a new pair of settings: full span, random, narrow, equal, at either
  // end of the value space, or a wide band that fits a full table.
  task automatic new_settings(bit wide);
    val_t        a;
    val_t        b;
    val_t        t;
    int unsigned mode;
    mode = wide ? 6 : $urandom_range(0, 5);
    case (mode)
      0: begin a = '0; b = VAL_MAX; end
      1: begin a = rand_val(); b = rand_val(); end
      2: begin
        a = rand_val();
        b = (a > VAL_MAX - 50) ? a - $urandom_range(0, 50) : a + $urandom_range(0, 50);
      end
      3: begin a = rand_val(); b = a; end
      4: begin a = VAL_MAX; b = VAL_MAX - $urandom_range(0, 40); end
      5: begin a = '0; b = val_t'($urandom_range(0, 40)); end
      default: begin a = rand_val() >> 1; b = a + $urandom_range(1000, 1 << 20); end
    endcase
    if ($urandom_range(0, 1)) begin
      t = a; a = b; b = t;
    end
    settle();
    if ($urandom_range(0, 1)) begin
      write_setting(REG_CURRENT, a);
      write_setting(REG_TARGET, b);
    end else begin
      write_setting(REG_TARGET, b);
      write_setting(REG_CURRENT, a);
    end
  endtask

  // Queue n items of one round. A normal round votes mostly from a small pool
  // so values repeat and tie; the rest is abstentions, votes just outside or
  // anywhere, and unused opcodes. A fill round pours in mostly new values to
  // overflow the table, with some repeats that must still count.
  task automatic queue_votes(int unsigned n, bit fill);
    val_t        lo;
    val_t        hi;
    val_t        v;
    val_t        pool[$];
    int unsigned roll;
    lo = (cur_setting < tgt_setting) ? cur_setting : tgt_setting;
    hi = (cur_setting < tgt_setting) ? tgt_setting : cur_setting;
    repeat ($urandom_range(1, 6)) pool.push_back(pick_in(lo, hi));
    if ($urandom_range(0, 3) == 0) pool.push_back(lo);
    if ($urandom_range(0, 3) == 0) pool.push_back(hi);
    for (int k = 0; k < n; k++) begin
      roll = $urandom_range(0, 99);
      if (fill) begin
        if (roll < 20) begin
          v = pool[$urandom_range(0, pool.size() - 1)];
        end else begin
          v = pick_in(lo, hi);
          pool.push_back(v);
        end
        post(OP_VOTE, v);
      end else if (roll < 62) begin
        post(OP_VOTE, pool[$urandom_range(0, pool.size() - 1)]);
      end else if (roll < 74) begin
        post(OP_ABSTAIN, rand_val());
      end else if (roll < 82) begin
        if ($urandom_range(0, 1) && lo != 0) v = lo - 1'b1;
        else if (hi != VAL_MAX) v = hi + 1'b1;
        else v = rand_val();
        post(OP_VOTE, v);
      end else if (roll < 92) begin
        post(OP_VOTE, rand_val());
      end else begin
        post(OP_UNUSED, rand_val());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned base;
    int unsigned round;
    bit          fill;
    val_t        lo;
    val_t        hi;

    for (int i = 0; i < ENTRIES; i++) tbl_cnt[i] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty round at reset settings: own vote for zero, nothing changes
    post(OP_DECIDE, rand_val());
    settle();

    // band 10..20: repeats, out-of-band votes on both sides, an abstention,
    // an unused opcode; then a tie that goes to the smaller value
    write_setting(REG_CURRENT, val_t'(10));
    write_setting(REG_TARGET, val_t'(20));
    post(OP_VOTE, val_t'(15));
    post(OP_VOTE, val_t'(15));
    post(OP_VOTE, val_t'(12));
    post(OP_VOTE, val_t'(25));
    post(OP_VOTE, val_t'(5));
    post(OP_ABSTAIN, VAL_MAX);
    post(OP_UNUSED, VAL_MAX);
    post(OP_DECIDE, '0);
    post(OP_VOTE, val_t'(18));
    post(OP_VOTE, val_t'(13));
    post(OP_DECIDE, VAL_MAX);
    settle();

    // full span, current above target; extremes of the value field tie
    write_setting(REG_CURRENT, VAL_MAX);
    write_setting(REG_TARGET, '0);
    post(OP_VOTE, '0);
    post(OP_ABSTAIN, '0);
    post(OP_VOTE, VAL_MAX);
    post(OP_DECIDE, '0);
    settle();

    // narrow the band mid-round so the leading stored value drops out
    write_setting(REG_CURRENT, val_t'(100));
    write_setting(REG_TARGET, val_t'(200));
    post(OP_VOTE, val_t'(150));
    post(OP_VOTE, val_t'(150));
    post(OP_VOTE, val_t'(120));
    settle();
    write_setting(REG_TARGET, val_t'(130));
    post(OP_DECIDE, rand_val());
    settle();

    // random rounds; one stretch runs without sender idling
    base  = cast_total;
    round = 0;
    while (cast_total - base < RANDOM_ITEMS) begin
      fill           = ($urandom_range(0, 11) == 0);
      sender_idle_en = !(round >= 30 && round < 45);
      if (fill) new_settings(1'b1);
      else if ($urandom_range(0, 2) == 0) new_settings(1'b0);
      queue_votes(fill ? $urandom_range(70, 100) : $urandom_range(0, 20), fill);
      // move one setting mid-round now and then
      if ($urandom_range(0, 7) == 0) begin
        lo = (cur_setting < tgt_setting) ? cur_setting : tgt_setting;
        hi = (cur_setting < tgt_setting) ? tgt_setting : cur_setting;
        settle();
        write_setting($urandom_range(0, 1) ? REG_TARGET : REG_CURRENT,
                      $urandom_range(0, 1) ? pick_in(lo, hi) : rand_val());
        queue_votes($urandom_range(0, 8), 1'b0);
      end
      post(OP_DECIDE, rand_val());
      round++;
    end

    settle();
    if (mismatch_cnt == 0 && verdict_q.size() == 0) begin
      $display("tb_ranged_plurality_vote: PASS");
    end else begin
      $display("tb_ranged_plurality_vote: FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/rpv_pkg.sv
hw/rtl/rpv_table.sv
hw/rtl/ranged_plurality_vote.sv
hw/rtl/rpv_checker.sv
bench/tb_ranged_plurality_vote.sv
